@@ design/c3r_pkg.sv @@
package c3r_pkg;

   localparam int CHANNELS  = 8;
   localparam int FEAT_W    = 16;
   localparam int COEF_W    = 16;
   localparam int NCOEF     = 584;
   localparam int COEF_ROWS = 73;
   localparam int BIAS_ROW  = 72;
   localparam int ACC_W     = 40;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   // pixel value 1.0 in Q8.8, used to fold the bias into the MAC sequence
   localparam logic [FEAT_W-1:0] ONE_Q88 = 16'd256;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LINE,
      ST_SLOT,
      ST_MAC,
      ST_DRAIN,
      ST_DONE
   } ctrl_state_type;

   // border handling of the output pixel under computation
   typedef struct packed {
      logic lower;
      logic right;
      logic r_gt0;
      logic r_gt1;
      logic c_gt0;
      logic c_gt1;
   } slot_sel_type;

   typedef struct packed {
      logic         line_rd;
      logic         line_wr;
      logic         mac_clear;
      logic         issue;
      logic         bias;
      logic [6:0]   row;
      logic [2:0]   ch;
      logic [1:0]   ta;
      logic [1:0]   tb;
      slot_sel_type sel;
      logic         load;
      logic         last;
      logic [15:0]  out_row;
      logic [10:0]  out_col;
   } dp_cmd_type;

endpackage

@@ design/c3r_if.sv @@
interface c3r_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [9:0]  coef_index;
   logic signed [15:0] coef_value;
   logic [15:0] feat0;
   logic [15:0] feat1;
   logic [15:0] feat2;
   logic [15:0] feat3;
   logic [15:0] feat4;
   logic [15:0] feat5;
   logic [15:0] feat6;
   logic [15:0] feat7;

   modport source (output valid, kind, coef_index, coef_value, feat0, feat1, feat2, feat3,
                   feat4, feat5, feat6, feat7, input ready);
   modport sink (input valid, kind, coef_index, coef_value, feat0, feat1, feat2, feat3,
                 feat4, feat5, feat6, feat7, output ready);
endinterface

interface c3r_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] res0;
   logic [15:0] res1;
   logic [15:0] res2;
   logic [15:0] res3;
   logic [15:0] res4;
   logic [15:0] res5;
   logic [15:0] res6;
   logic [15:0] res7;
   logic [15:0] out_row;
   logic [10:0] out_col;
   logic        last_of_run;

   modport source (output valid, res0, res1, res2, res3, res4, res5, res6, res7, out_row,
                   out_col, last_of_run, input ready);
   modport sink (input valid, res0, res1, res2, res3, res4, res5, res6, res7, out_row,
                 out_col, last_of_run, output ready);
endinterface

@@ design/c3r_ctrl.sv @@
module c3r_ctrl
   import c3r_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_kind,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   output logic [$clog2(MAX_WIDTH)-1:0] line_addr,
   output dp_cmd_type           cmd
);

   localparam int CW = $clog2(MAX_WIDTH);

   ctrl_state_type state_ff, state_in;
   logic [11:0]    width_ff, width_in;
   logic [15:0]    height_ff, height_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [15:0]    row_ff, row_in;
   logic [CW-1:0]  pc_ff, pc_in;
   logic [15:0]    pr_ff, pr_in;
   logic [3:0]     mask_ff, mask_in;
   logic [1:0]     slot_ff, slot_in;
   logic [6:0]     step_ff, step_in;
   logic [2:0]     ch_ff, ch_in;
   logic [1:0]     ta_ff, ta_in;
   logic [1:0]     tb_ff, tb_in;
   logic           drain_ff, drain_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic [31:0]    eff_w, eff_h, c_eff, r_eff;
   logic           last_col, last_row, px_fire, cfg_hit, out_free;
   slot_sel_type   sel;
   logic [31:0]    orow, ocol;

   // effective frame size and clamped position
   always_comb begin
      eff_w = 32'(width_ff);
      if (eff_w == 32'd0) begin
         eff_w = 32'd1;
      end else if (eff_w > 32'(MAX_WIDTH)) begin
         eff_w = 32'(MAX_WIDTH);
      end
      eff_h = (height_ff == 16'd0) ? 32'd1 : 32'(height_ff);
      c_eff = (32'(col_ff) >= eff_w) ? eff_w - 32'd1 : 32'(col_ff);
      r_eff = (32'(row_ff) >= eff_h) ? eff_h - 32'd1 : 32'(row_ff);
      last_col = (c_eff == eff_w - 32'd1);
      last_row = (r_eff == eff_h - 32'd1);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign px_fire   = req_valid && req_ready && req_kind;
   assign cfg_hit   = csr_we && (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (px_fire) state_in = ST_LINE;
         ST_LINE:  state_in = ST_SLOT;
         ST_SLOT: begin
            if (mask_ff[slot_ff]) begin
               state_in = ST_MAC;
            end else if (slot_ff == 2'd3) begin
               state_in = ST_IDLE;
            end
         end
         ST_MAC:   if (step_ff == 7'(BIAS_ROW)) state_in = ST_DRAIN;
         ST_DRAIN: if (drain_ff) state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = (slot_ff == 2'd3) ? ST_IDLE : ST_SLOT;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // counters and per-pixel bookkeeping
   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pc_in        = pc_ff;
      pr_in        = pr_ff;
      mask_in      = mask_ff;
      slot_in      = slot_ff;
      step_in      = step_ff;
      ch_in        = ch_ff;
      ta_in        = ta_ff;
      tb_in        = tb_ff;
      drain_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      if (csr_we && csr_index == CSR_FRAME_WIDTH)  width_in  = csr_wdata[11:0];
      if (csr_we && csr_index == CSR_FRAME_HEIGHT) height_in = csr_wdata;
      if (cfg_hit) begin
         col_in = '0;
         row_in = '0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (px_fire) begin
               pc_in   = CW'(c_eff);
               pr_in   = 16'(r_eff);
               slot_in = 2'd0;
               mask_in = {last_row && last_col, last_row && (c_eff != 0),
                          (r_eff != 0) && last_col, (r_eff != 0) && (c_eff != 0)};
               if (last_col) begin
                  col_in = '0;
                  row_in = last_row ? 16'd0 : 16'(r_eff + 32'd1);
               end else begin
                  col_in = CW'(c_eff + 32'd1);
                  row_in = 16'(r_eff);
               end
            end
         end
         ST_SLOT: begin
            step_in = '0;
            ch_in   = '0;
            ta_in   = '0;
            tb_in   = '0;
            if (!mask_ff[slot_ff] && slot_ff != 2'd3) slot_in = slot_ff + 2'd1;
         end
         ST_MAC: begin
            // walk taps inner, channels outer; the final step is the bias row
            step_in = step_ff + 7'd1;
            if (tb_ff == 2'd2) begin
               tb_in = '0;
               if (ta_ff == 2'd2) begin
                  ta_in = '0;
                  ch_in = ch_ff + 3'd1;
               end else begin
                  ta_in = ta_ff + 2'd1;
               end
            end else begin
               tb_in = tb_ff + 2'd1;
            end
         end
         ST_DRAIN: drain_in = 1'b1;
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (slot_ff != 2'd3) slot_in = slot_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

   // slot geometry
   always_comb begin
      sel.lower = slot_ff[1];
      sel.right = slot_ff[0];
      sel.r_gt0 = (pr_ff != 16'd0);
      sel.r_gt1 = (pr_ff > 16'd1);
      sel.c_gt0 = (pc_ff != '0);
      sel.c_gt1 = (32'(pc_ff) > 32'd1);
      orow = slot_ff[1] ? 32'(pr_ff) : 32'(pr_ff) - 32'd1;
      ocol = slot_ff[0] ? 32'(pc_ff) : 32'(pc_ff) - 32'd1;
   end

   // datapath commands
   always_comb begin
      line_addr     = (state_ff == ST_IDLE) ? CW'(c_eff) : pc_ff;
      cmd.line_rd   = px_fire;
      cmd.line_wr   = (state_ff == ST_LINE);
      cmd.mac_clear = (state_ff == ST_SLOT) && mask_ff[slot_ff];
      cmd.issue     = (state_ff == ST_MAC);
      cmd.bias      = (step_ff == 7'(BIAS_ROW));
      cmd.row       = step_ff;
      cmd.ch        = ch_ff;
      cmd.ta        = ta_ff;
      cmd.tb        = tb_ff;
      cmd.sel       = sel;
      cmd.load      = (state_ff == ST_DONE) && out_free;
      cmd.last      = ((mask_ff >> (3'(slot_ff) + 3'd1)) == 4'd0);
      cmd.out_row   = orow[15:0];
      cmd.out_col   = ocol[10:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= 12'd2048;
         height_ff    <= 16'd1080;
         col_ff       <= '0;
         row_ff       <= '0;
         mask_ff      <= '0;
         slot_ff      <= '0;
         step_ff      <= '0;
         ch_ff        <= '0;
         ta_ff        <= '0;
         tb_ff        <= '0;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         mask_ff      <= mask_in;
         slot_ff      <= slot_in;
         step_ff      <= step_in;
         ch_ff        <= ch_in;
         ta_ff        <= ta_in;
         tb_ff        <= tb_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pc_ff <= pc_in;
      pr_ff <= pr_in;
   end

   // a result is never loaded over one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // MAC only runs for a result that exists
   a_slot_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> mask_ff[slot_ff])
      else $error("MAC on empty slot");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> (step_ff <= 7'(BIAS_ROW)))
      else $error("MAC step out of range");

   // a pixel transaction always updates the line stores next
   a_pixel_line: assert property (@(posedge clock) disable iff (reset)
      px_fire |=> (state_ff == ST_LINE))
      else $error("pixel not written to line stores");

endmodule

@@ design/c3r_dp.sv @@
module c3r_dp
   import c3r_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                          clock,
   input  dp_cmd_type                    cmd,
   input  logic                          coef_we,
   input  logic [9:0]                    coef_index,
   input  logic signed [COEF_W-1:0]      coef_value,
   input  logic [CHANNELS*FEAT_W-1:0]    feat,
   input  logic [$clog2(MAX_WIDTH)-1:0]  line_addr,
   output logic [CHANNELS*FEAT_W-1:0]    res,
   output logic [15:0]                   out_row,
   output logic [10:0]                   out_col,
   output logic                          last_of_run
);

   localparam int PW = CHANNELS * FEAT_W;

   logic [COEF_W-1:0] bank_mem [CHANNELS][COEF_ROWS];
   logic [PW-1:0]     lp_mem   [MAX_WIDTH];
   logic [PW-1:0]     lp2_mem  [MAX_WIDTH];
   logic [PW-1:0]     win_ff   [3][3];
   logic [PW-1:0]     lp_rd_ff, lp2_rd_ff, pix_ff;

   logic [COEF_W-1:0]       w_rd_ff  [CHANNELS];
   logic [FEAT_W-1:0]       px_ff;
   logic                    va_ff, vb_ff;
   logic signed [32:0]      prod_ff  [CHANNELS];
   logic signed [ACC_W-1:0] acc_ff   [CHANNELS];
   logic [PW-1:0]           res_ff;
   logic [15:0]             out_row_ff;
   logic [10:0]             out_col_ff;
   logic                    last_ff;

   logic [1:0]        wr, wc;
   logic [PW-1:0]     win_sel;
   logic [FEAT_W-1:0] px_sel;

   // coefficient banks: one per output lane, row = index / 8
   always_ff @(posedge clock) begin
      for (int k = 0; k < CHANNELS; k++) begin
         if (coef_we && 10'(coef_index) < 10'(NCOEF) && coef_index[2:0] == 3'(k)) begin
            bank_mem[k][coef_index[9:3]] <= coef_value;
         end
         if (cmd.issue) w_rd_ff[k] <= bank_mem[k][cmd.row];
      end
   end

   // line stores and window
   always_ff @(posedge clock) begin
      if (cmd.line_rd) begin
         lp_rd_ff  <= lp_mem[line_addr];
         lp2_rd_ff <= lp2_mem[line_addr];
         pix_ff    <= feat;
      end
      if (cmd.line_wr) begin
         lp2_mem[line_addr] <= lp_rd_ff;
         lp_mem[line_addr]  <= pix_ff;
         for (int a = 0; a < 3; a++) begin
            win_ff[a][0] <= win_ff[a][1];
            win_ff[a][1] <= win_ff[a][2];
         end
         win_ff[0][2] <= lp2_rd_ff;
         win_ff[1][2] <= lp_rd_ff;
         win_ff[2][2] <= pix_ff;
      end
   end

   // tap to window position with replicated borders
   always_comb begin
      if (cmd.sel.lower) begin
         wr = (cmd.ta == 2'd0 && cmd.sel.r_gt0) ? 2'd1 : 2'd2;
      end else begin
         wr = (cmd.ta == 2'd0) ? (cmd.sel.r_gt1 ? 2'd0 : 2'd1) : cmd.ta;
      end
      if (cmd.sel.right) begin
         wc = (cmd.tb == 2'd0 && cmd.sel.c_gt0) ? 2'd1 : 2'd2;
      end else begin
         wc = (cmd.tb == 2'd0) ? (cmd.sel.c_gt1 ? 2'd0 : 2'd1) : cmd.tb;
      end
      win_sel = win_ff[wr][wc];
      px_sel  = win_sel[{cmd.ch, 4'b0000} +: FEAT_W];
   end

   // MAC pipeline: operand fetch, multiply, accumulate
   always_ff @(posedge clock) begin
      va_ff <= cmd.issue;
      vb_ff <= va_ff;
      if (cmd.issue) px_ff <= cmd.bias ? ONE_Q88 : px_sel;
      for (int k = 0; k < CHANNELS; k++) begin
         prod_ff[k] <= $signed({1'b0, px_ff}) * $signed(w_rd_ff[k]);
         if (cmd.mac_clear) begin
            acc_ff[k] <= '0;
         end else if (vb_ff) begin
            acc_ff[k] <= acc_ff[k] + ACC_W'(prod_ff[k]);
         end
      end
   end

   // ReLU, round half up to Q8.8, saturate
   always_ff @(posedge clock) begin
      logic signed [ACC_W-1:0] rnd;
      if (cmd.load) begin
         for (int k = 0; k < CHANNELS; k++) begin
            rnd = (acc_ff[k] + ACC_W'(2048)) >>> 12;
            if (acc_ff[k] <= 0) begin
               res_ff[k*FEAT_W +: FEAT_W] <= '0;
            end else if (rnd > ACC_W'(65535)) begin
               res_ff[k*FEAT_W +: FEAT_W] <= 16'hFFFF;
            end else begin
               res_ff[k*FEAT_W +: FEAT_W] <= rnd[15:0];
            end
         end
         out_row_ff <= cmd.out_row;
         out_col_ff <= cmd.out_col;
         last_ff    <= cmd.last;
      end
   end

   assign res         = res_ff;
   assign out_row     = out_row_ff;
   assign out_col     = out_col_ff;
   assign last_of_run = last_ff;

endmodule

@@ design/conv3x3_8ch_to_8ch_relu.sv @@
// 3x3 convolution, 8 input to 8 output channels, ReLU, replicated borders.
// req_chan takes coefficient transactions (kind 0: coef_index, coef_value)
// and feature pixel transactions (kind 1: feat0..feat7) in raster order.
// rsp_chan returns output pixels res0..res7 with out_row/out_col; the last
// result caused by one pixel carries last_of_run. A pixel gives 0 to 4
// results, which trail the input by at most one row and one column.
// Sequence: a coefficient transaction is written to its bank as it is
// accepted. A pixel goes through a line store read and update, then per
// result a setup step, the MAC steps (72 taps and the bias on eight output
// lanes that share one pixel operand), a pipeline drain and a load; each
// of the four result slots that gives nothing is skipped in a slot step;
// the lane multipliers and coefficient bank read port set the MAC length.
// req_chan is ready only while no pixel transaction is in progress. A finished result waits in
// the output register; if rsp_chan stalls, the next result's MAC still runs
// and then holds until the register frees.
// csr: index 0 frame_width, index 1 frame_height; a write restarts the frame.
// Reset restores width 2048, height 1080 and position 0,0; coefficient and
// line stores keep whatever they held and must be loaded before use.
module conv3x3_8ch_to_8ch_relu
   import c3r_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                 clock,
   input  logic                 reset,
   c3r_req_if.sink              req_chan,
   c3r_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   dp_cmd_type                   cmd;
   logic [$clog2(MAX_WIDTH)-1:0] line_addr;
   logic [CHANNELS*FEAT_W-1:0]   feat;
   logic [CHANNELS*FEAT_W-1:0]   res;
   logic                         coef_we;

   assign feat = {req_chan.feat7, req_chan.feat6, req_chan.feat5, req_chan.feat4,
                  req_chan.feat3, req_chan.feat2, req_chan.feat1, req_chan.feat0};
   assign coef_we = req_chan.valid && req_chan.ready && !req_chan.kind;

   c3r_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .line_addr (line_addr),
      .cmd       (cmd)
   );

   c3r_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .coef_we     (coef_we),
      .coef_index  (req_chan.coef_index),
      .coef_value  (req_chan.coef_value),
      .feat        (feat),
      .line_addr   (line_addr),
      .res         (res),
      .out_row     (rsp_chan.out_row),
      .out_col     (rsp_chan.out_col),
      .last_of_run (rsp_chan.last_of_run)
   );

   assign rsp_chan.res0 = res[0*FEAT_W +: FEAT_W];
   assign rsp_chan.res1 = res[1*FEAT_W +: FEAT_W];
   assign rsp_chan.res2 = res[2*FEAT_W +: FEAT_W];
   assign rsp_chan.res3 = res[3*FEAT_W +: FEAT_W];
   assign rsp_chan.res4 = res[4*FEAT_W +: FEAT_W];
   assign rsp_chan.res5 = res[5*FEAT_W +: FEAT_W];
   assign rsp_chan.res6 = res[6*FEAT_W +: FEAT_W];
   assign rsp_chan.res7 = res[7*FEAT_W +: FEAT_W];

endmodule

@@ tb/conv_checker.sv @@
// Watches the request, response and csr ports, predicts every output pixel
// of the 3x3 convolution and compares the responses in order.
module conv_checker
   import c3r_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   c3r_req_if                   req,
   c3r_rsp_if                   rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   output int                   fail_count,
   output int                   pending
);

   localparam int LINE_MAX = 2048;

   typedef struct {
      logic [15:0] res [CHANNELS];
      logic [15:0] row;
      logic [10:0] col;
      logic        last;
   } out_pixel_type;

   out_pixel_type pixel_q [$];
   logic [15:0] coefs [NCOEF];
   logic [15:0] line1 [LINE_MAX][CHANNELS];
   logic [15:0] line2 [LINE_MAX][CHANNELS];
   logic [15:0] win [3][3][CHANNELS];
   int          row_cnt, col_cnt, frame_w, frame_h;

   assign pending = pixel_q.size();

   // one output pixel from the window, with row/col selects for the borders
   task automatic conv_pixel(input int rs[3], input int cs[3], input int orow,
                             input int ocol);
      out_pixel_type op;
      longint     acc;
      int         idx;
      longint     v;
      for (int k = 0; k < CHANNELS; k++) begin
         acc = longint'($signed(coefs[NCOEF - CHANNELS + k])) * 256;
         for (int ch = 0; ch < CHANNELS; ch++)
            for (int a = 0; a < 3; a++)
               for (int b = 0; b < 3; b++) begin
                  idx = ch * 72 + (a * 3 + b) * 8 + k;
                  acc += longint'(win[rs[a]][cs[b]][ch]) * longint'($signed(coefs[idx]));
               end
         if (acc <= 0) begin
            op.res[k] = 16'd0;
         end else begin
            v = (acc + 2048) >>> 12;
            op.res[k] = (v > 65535) ? 16'hFFFF : v[15:0];
         end
      end
      op.row  = orow[15:0];
      op.col  = ocol[10:0];
      op.last = 1'b0;
      pixel_q.push_back(op);
   endtask

   // pixel arrival: shift window, update line stores, queue finished outputs
   task automatic take_pixel();
      int w, h, r, c, n0;
      int rs[3], cs[3];
      logic [15:0] px [CHANNELS];
      bit lastc, lastr;
      w = (frame_w < 1) ? 1 : ((frame_w > LINE_MAX) ? LINE_MAX : frame_w);
      h = (frame_h < 1) ? 1 : frame_h;
      r = row_cnt;
      c = col_cnt;
      if (c >= w) c = w - 1;
      if (r >= h) r = h - 1;
      px = '{req.feat0, req.feat1, req.feat2, req.feat3,
             req.feat4, req.feat5, req.feat6, req.feat7};
      for (int a = 0; a < 3; a++) begin
         win[a][0] = win[a][1];
         win[a][1] = win[a][2];
      end
      for (int ch = 0; ch < CHANNELS; ch++) begin
         win[0][2][ch] = line2[c][ch];
         win[1][2][ch] = line1[c][ch];
         win[2][2][ch] = px[ch];
         line2[c][ch]  = line1[c][ch];
         line1[c][ch]  = px[ch];
      end
      lastc = (c == w - 1);
      lastr = (r == h - 1);
      n0 = pixel_q.size();
      if (r > 0) begin
         rs = '{(r - 1 > 0) ? 0 : 1, 1, 2};
         if (c > 0) begin
            cs = '{(c - 1 > 0) ? 0 : 1, 1, 2};
            conv_pixel(rs, cs, r - 1, c - 1);
         end
         if (lastc) begin
            cs = '{(c > 0) ? 1 : 2, 2, 2};
            conv_pixel(rs, cs, r - 1, c);
         end
      end
      if (lastr) begin
         rs = '{(r > 0) ? 1 : 2, 2, 2};
         if (c > 0) begin
            cs = '{(c - 1 > 0) ? 0 : 1, 1, 2};
            conv_pixel(rs, cs, r, c - 1);
         end
         if (lastc) begin
            cs = '{(c > 0) ? 1 : 2, 2, 2};
            conv_pixel(rs, cs, r, c);
         end
      end
      if (pixel_q.size() > n0) pixel_q[pixel_q.size() - 1].last = 1'b1;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_cnt = c;
      row_cnt = r;
   endtask

   task automatic check_rsp();
      out_pixel_type exp_px;
      logic [15:0] got [CHANNELS];
      if (pixel_q.size() == 0) begin
         $error("response transaction with no output pixel expected");
         fail_count++;
         return;
      end
      exp_px = pixel_q.pop_front();
      got = '{rsp.res0, rsp.res1, rsp.res2, rsp.res3,
              rsp.res4, rsp.res5, rsp.res6, rsp.res7};
      for (int k = 0; k < CHANNELS; k++)
         if (got[k] !== exp_px.res[k]) begin
            $error("res%0d expected %0d actual %0d", k, exp_px.res[k], got[k]);
            fail_count++;
         end
      if (rsp.out_row !== exp_px.row) begin
         $error("out_row expected %0d actual %0d", exp_px.row, rsp.out_row);
         fail_count++;
      end
      if (rsp.out_col !== exp_px.col) begin
         $error("out_col expected %0d actual %0d", exp_px.col, rsp.out_col);
         fail_count++;
      end
      if (rsp.last_of_run !== exp_px.last) begin
         $error("last_of_run expected %0d actual %0d", exp_px.last, rsp.last_of_run);
         fail_count++;
      end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         row_cnt = 0;
         col_cnt = 0;
         frame_w = 2048;
         frame_h = 1080;
         pixel_q.delete();
      end else begin
         // csr writes restart the frame
         if (csr_we) begin
            if (csr_index == CSR_FRAME_WIDTH) begin
               frame_w = int'(csr_wdata[11:0]);
               row_cnt = 0;
               col_cnt = 0;
            end else if (csr_index == CSR_FRAME_HEIGHT) begin
               frame_h = int'(csr_wdata);
               row_cnt = 0;
               col_cnt = 0;
            end
         end
         if (req.valid && req.ready) begin
            if (req.kind == 1'b0) begin
               if (req.coef_index < NCOEF) coefs[req.coef_index] = req.coef_value;
            end else begin
               take_pixel();
            end
         end
         if (rsp.valid && rsp.ready) check_rsp();
      end
   end

endmodule

@@ tb/tb_top.sv @@
// Stimulus and verdict for the 3x3 convolution layer.
module tb_top;
   import c3r_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE      = 400;

   typedef logic [15:0] feat_arr_type [CHANNELS];

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;
   int                   fail_count, pending, cycles;
   bit                   quiet;

   c3r_req_if req_chan ();
   c3r_rsp_if rsp_chan ();

   conv3x3_8ch_to_8ch_relu u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   conv_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .rsp        (rsp_chan),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // response backpressure
   initial rsp_chan.ready = 1'b0;
   always @(negedge clock) begin
      rsp_chan.ready = quiet ? 1'b1 : ($urandom_range(99) >= 35);
   end

   task automatic send(input logic kind, input logic [9:0] idx, input logic [15:0] cv,
                       input feat_arr_type f);
      if (!quiet && $urandom_range(99) < 35) repeat ($urandom_range(1, 5)) @(negedge clock);
      req_chan.kind       = kind;
      req_chan.coef_index = idx;
      req_chan.coef_value = cv;
      req_chan.feat0 = f[0]; req_chan.feat1 = f[1]; req_chan.feat2 = f[2];
      req_chan.feat3 = f[3]; req_chan.feat4 = f[4]; req_chan.feat5 = f[5];
      req_chan.feat6 = f[6]; req_chan.feat7 = f[7];
      req_chan.valid = 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   task automatic send_coef(input logic [9:0] idx, input logic [15:0] cv);
      feat_arr_type f;
      foreach (f[i]) f[i] = 16'($urandom);
      send(1'b0, idx, cv, f);
   endtask

   task automatic send_pixel(input feat_arr_type f);
      send(1'b1, 10'($urandom), 16'($urandom), f);
   endtask

   // mode 0 small, 1 full range, 2 zero weights with random bias
   task automatic load_coefs(input int mode);
      logic [15:0] v;
      for (int i = 0; i < NCOEF; i++) begin
         case (mode)
            0: v = 16'($signed($urandom_range(126)) - 63);
            1: v = 16'($urandom);
            default: v = (i >= NCOEF - CHANNELS) ? 16'($urandom) : 16'd0;
         endcase
         send_coef(i[9:0], v);
      end
   endtask

   function automatic feat_arr_type rand_feat();
      feat_arr_type f;
      int        m;
      m = $urandom_range(9);
      foreach (f[i]) begin
         case (m)
            0: f[i] = 16'd0;
            1: f[i] = 16'hFFFF;
            2, 3: f[i] = 16'($urandom);
            default: f[i] = 16'($urandom_range(255));
         endcase
      end
      return f;
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] d);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = d;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // drain outstanding outputs and let a trailing pixel finish
   task automatic wait_idle();
      wait (pending == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_frame(input logic [15:0] w, input logic [15:0] h);
      wait_idle();
      csr_write(CSR_FRAME_WIDTH, w);
      csr_write(CSR_FRAME_HEIGHT, h);
   endtask

   initial begin
      feat_arr_type f;
      int        sent, w, h, npix;
      req_chan.valid = 1'b0;
      req_chan.kind = 1'b0;
      req_chan.coef_index = '0;
      req_chan.coef_value = '0;
      req_chan.feat0 = '0; req_chan.feat1 = '0; req_chan.feat2 = '0; req_chan.feat3 = '0;
      req_chan.feat4 = '0; req_chan.feat5 = '0; req_chan.feat6 = '0; req_chan.feat7 = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      quiet = 1'b0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: bias only, biases at both extremes, out-of-range coefficient indices, single pixel frame
      load_coefs(2);
      send_coef(10'(NCOEF - CHANNELS), 16'h7FFF);
      send_coef(10'(NCOEF - CHANNELS + 1), 16'h8000);
      send_coef(10'd1023, 16'h1234);
      send_coef(10'(NCOEF), 16'hFFFF);
      set_frame(16'd1, 16'd1);
      f = '{default: 16'hFFFF};
      send_pixel(f);

      // small weights, 3x2 frame with extreme pixels
      wait_idle();
      load_coefs(0);
      set_frame(16'd3, 16'd2);
      f = '{default: 16'h0000};     send_pixel(f);
      f = '{default: 16'hFFFF};     send_pixel(f);
      f = '{default: 16'hAAAA};     send_pixel(f);
      f = '{default: 16'h5555};     send_pixel(f);
      f = '{default: 16'h00FF};     send_pixel(f);
      f = '{default: 16'hFF00};     send_pixel(f);

      // zero width and zero height clamp to one
      set_frame(16'd0, 16'd0);
      send_pixel(rand_feat());
      send_pixel(rand_feat());

      // width above the line store clamps; single-row partial frame
      set_frame(16'hFFF, 16'd1);
      for (int i = 0; i < 12; i++) send_pixel(rand_feat());

      // tallest frame, partial
      set_frame(16'd2, 16'hFFFF);
      for (int i = 0; i < 8; i++) send_pixel(rand_feat());

      // random frames, full or cut short; occasional coefficient reloads
      sent = 0;
      while (sent < 260) begin
         w = $urandom_range(1, 6);
         h = $urandom_range(1, 5);
         npix = w * h;
         if ($urandom_range(9) == 0) npix = $urandom_range(1, npix);
         wait_idle();
         quiet = ($urandom_range(5) == 0);
         case ($urandom_range(9))
            0: load_coefs(1);
            1: load_coefs(0);
            2: load_coefs(2);
            3: send_coef(10'($urandom_range(NCOEF - 1)), 16'($urandom));
            default: ;
         endcase
         set_frame(w[15:0], h[15:0]);
         for (int i = 0; i < npix; i++) begin
            if ($urandom_range(19) == 0) begin
               send_coef(10'($urandom_range(NCOEF, 1023)), 16'($urandom));
            end
            send_pixel(rand_feat());
         end
         sent += npix;
      end
      quiet = 1'b0;
      wait_idle();

      if (fail_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
